[hw/rtl/hpk_pkg.sv]
// ----------------------------------------------------------------------------
// hpk_pkg
// Shared types and canonical code tables for the HPACK Huffman decoder.
// ----------------------------------------------------------------------------
package hpk_pkg;

    localparam int SymCount = 257;
    localparam int MaxLen   = 30;
    localparam int MinLen   = 5;
    localparam int BufW     = 37;
    localparam int WinW     = 30;

    // result kinds
    localparam logic [1:0] KIND_SYM    = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_BADPAD = 2'd2;

    localparam logic [8:0] EOS_SYM = 9'd256;

    typedef logic [30:0] t_lim_tab [0:31];
    typedef logic [8:0]  t_base_tab [0:31];
    typedef logic [8:0]  t_sym_tab [0:SymCount-1];
    typedef logic [4:0]  t_len_src [0:SymCount-1];

    // result of the shared match unit
    typedef struct packed {
        logic       hit;
        logic [8:0] sym;
    } t_match;

    // code length of each symbol (RFC 7541 Appendix B)
    localparam t_len_src CODE_LEN = '{
        5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,
        5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
        5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,
        5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
        5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
        5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,
        5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
        5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
        5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,
        5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
        5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,
        5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
        5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,
        5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
        5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,
        5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
        5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,
        5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
        5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,
        5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
        5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,
        5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
        5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,
        5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26,
        5'd30
    };

    // left-justified first code (sel=0) or limit first+count (sel=1) per length
    function automatic t_lim_tab f_just(input bit sel);
        t_lim_tab res;
        longint   code;
        longint   num;
        res  = '{default: '0};
        code = 0;
        for (int l = 1; l <= MaxLen; l++) begin
            num = 0;
            for (int s = 0; s < SymCount; s++) begin
                if (int'(CODE_LEN[s]) == l) begin
                    num++;
                end
            end
            if (sel) begin
                res[l] = 31'((code + num) << (MaxLen - l));
            end else begin
                res[l] = 31'(code << (MaxLen - l));
            end
            code = (code + num) << 1;
        end
        return res;
    endfunction

    // position of the first symbol of each length in the sorted list
    function automatic t_base_tab f_base();
        t_base_tab res;
        int        pos;
        res = '{default: '0};
        pos = 0;
        for (int l = 1; l <= MaxLen; l++) begin
            res[l] = 9'(pos);
            for (int s = 0; s < SymCount; s++) begin
                if (int'(CODE_LEN[s]) == l) begin
                    pos++;
                end
            end
        end
        return res;
    endfunction

    // symbols sorted by length, then by value
    function automatic t_sym_tab f_by_code();
        t_sym_tab res;
        int       pos;
        res = '{default: '0};
        pos = 0;
        for (int l = 1; l <= MaxLen; l++) begin
            for (int s = 0; s < SymCount; s++) begin
                if (int'(CODE_LEN[s]) == l) begin
                    res[pos] = 9'(s);
                    pos++;
                end
            end
        end
        return res;
    endfunction

    localparam t_lim_tab  FIRST_J = f_just(1'b0);
    localparam t_lim_tab  LIMIT_J = f_just(1'b1);
    localparam t_base_tab BASE    = f_base();
    localparam t_sym_tab  BY_CODE = f_by_code();

endpackage

[hw/rtl/hpk_code_match.sv]
// ----------------------------------------------------------------------------
// hpk_code_match
// Shared match unit: tests one code length against the left-aligned window
// and maps a hit to its symbol through the canonical tables.
// ----------------------------------------------------------------------------
module hpk_code_match
    import hpk_pkg::*;
(
    input  logic [WinW-1:0] i_window,
    input  logic [4:0]      i_len,
    output t_match          o_match
);

    logic [WinW-1:0] offs;
    logic [WinW-1:0] rank;
    logic [8:0]      idx;

    // window below the length's limit means the code has this length
    assign o_match.hit = ({1'b0, i_window} < LIMIT_J[i_len]);

    // offset within the length group, right-aligned
    assign offs = i_window - FIRST_J[i_len][WinW-1:0];
    assign rank = offs >> (5'(MaxLen) - i_len);
    assign idx  = BASE[i_len] + rank[8:0];

    assign o_match.sym = BY_CODE[idx];

endmodule

[hw/rtl/hpack_huffman_decoder_core.sv]
// ----------------------------------------------------------------------------
// hpack_huffman_decoder_core
// HPACK/QPACK Huffman string decoder, one coded byte per transaction.
// ----------------------------------------------------------------------------
// Takes one coded byte per input transaction and returns the decoded symbols
// it completes (at most seven), then a status result when the byte is marked
// end of string. A sequencer searches code lengths upward from 5 through one
// shared compare unit, one length per cycle. Each byte is accepted, its
// symbols are found in turn, a final search finds no complete code, the last
// symbol is released and, at end of string, the status result follows. A byte
// that arrives after an EOS code inside the string skips the search. The block
// takes no new byte until the last result of the current one has entered the
// output register.
module hpack_huffman_decoder_core
    import hpk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_code_byte,
    input  logic       i_end_of_string,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_symbol,
    output logic [1:0] o_kind,
    output logic       o_run_last
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SYM    = 5'b00100,
        S_FINISH = 5'b01000,
        S_STAT   = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [BufW-1:0]   r_buf, n_buf;      // pending bits, MSB aligned
    logic [5:0]        r_cnt, n_cnt;
    logic              r_bad, n_bad;
    logic              r_eos, n_eos;
    logic [4:0]        r_len, n_len;
    logic [2:0]        r_nsym, n_nsym;
    logic              r_pend_v, n_pend_v;
    logic [7:0]        r_pend, n_pend;
    logic              r_ov, n_ov;
    logic [7:0]        r_osym, n_osym;
    logic [1:0]        r_okind, n_okind;
    logic              r_olast, n_olast;

    t_match            match;
    logic              out_free;
    logic [BufW-1:0]   clamp_buf;
    logic [5:0]        clamp_cnt;
    logic [6:0]        pad_mask;
    logic              pad_ok;

    hpk_code_match u_match (
        .i_window (r_buf[BufW-1 -: WinW]),
        .i_len    (r_len),
        .o_match  (match)
    );

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    // keep the newest 29 pending bits before a new byte
    assign clamp_cnt = (r_cnt > 6'd29) ? 6'd29 : r_cnt;
    assign clamp_buf = (r_cnt > 6'd29) ? (r_buf << (r_cnt - 6'd29)) : r_buf;

    // padding: up to 7 leftover bits, all ones
    assign pad_mask = 7'h7f >> r_cnt[2:0];
    assign pad_ok   = !r_bad && (r_cnt <= 6'd7) && (&(r_buf[BufW-1 -: 7] | pad_mask));

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_bad    = r_bad;
        n_eos    = r_eos;
        n_len    = r_len;
        n_nsym   = r_nsym;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_ov     = r_ov && !i_ready;
        n_osym   = r_osym;
        n_okind  = r_okind;
        n_olast  = r_olast;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_eos  = i_end_of_string;
                    n_nsym = '0;
                    n_len  = 5'(MinLen);
                    if (!r_bad) begin
                        n_buf   = clamp_buf | ({i_code_byte, 29'b0} >> clamp_cnt);
                        n_cnt   = clamp_cnt + 6'd8;
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_nsym == 3'd7 || {1'b0, r_len} > r_cnt) begin
                    n_state = S_FINISH;
                end else if (match.hit) begin
                    n_state = S_SYM;
                end else if (r_len == 5'(MaxLen)) begin
                    n_state = S_FINISH;
                end else begin
                    n_len = r_len + 5'd1;
                end
            end
            S_SYM: begin
                if (match.sym == EOS_SYM) begin
                    n_bad   = 1'b1;
                    n_buf   = '0;
                    n_cnt   = '0;
                    n_state = S_FINISH;
                end else if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_ov    = 1'b1;
                        n_osym  = r_pend;
                        n_okind = KIND_SYM;
                        n_olast = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    n_pend   = match.sym[7:0];
                    n_buf    = r_buf << r_len;
                    n_cnt    = r_cnt - {1'b0, r_len};
                    n_nsym   = r_nsym + 3'd1;
                    n_len    = 5'(MinLen);
                    n_state  = S_SEARCH;
                end
            end
            S_FINISH: begin
                if (r_pend_v) begin
                    if (out_free) begin
                        n_ov     = 1'b1;
                        n_osym   = r_pend;
                        n_okind  = KIND_SYM;
                        n_olast  = !r_eos;
                        n_pend_v = 1'b0;
                    end
                end else if (r_eos) begin
                    n_state = S_STAT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_osym  = '0;
                    n_okind = pad_ok ? KIND_OK : KIND_BADPAD;
                    n_olast = 1'b1;
                    n_buf   = '0;
                    n_cnt   = '0;
                    n_bad   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_buf    <= '0;
            r_cnt    <= '0;
            r_bad    <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_buf    <= n_buf;
            r_cnt    <= n_cnt;
            r_bad    <= n_bad;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_eos   <= n_eos;
        r_len   <= n_len;
        r_nsym  <= n_nsym;
        r_pend  <= n_pend;
        r_osym  <= n_osym;
        r_okind <= n_okind;
        r_olast <= n_olast;
    end

    assign o_valid    = r_ov;
    assign o_symbol   = r_osym;
    assign o_kind     = r_okind;
    assign o_run_last = r_olast;

endmodule

[tb/hpack_huffman_decoder_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpack_huffman_decoder_core_tb
// Self-checking bench for the HPACK Huffman string decoder.
// ----------------------------------------------------------------------------
// A behavioral decoder built on the canonical code predicts the symbols and
// the status result for every accepted coded byte. Strings are mostly
// encodings of random text padded with ones; the rest is raw noise, encodings
// with broken padding and strings with an embedded EOS code. The sender works in
// bursts and the receiver stalls on a pattern of its own.
module hpack_huffman_decoder_core_tb;
    import hpk_pkg::*;

    // one decoded result
    typedef struct packed {
        logic [7:0] symbol;
        logic [1:0] kind;
        logic       run_last;
    } t_dec_res;

    // ------------------------------------------------------------------
    // canonical code tables and string decoder state
    // ------------------------------------------------------------------
    class huff_scoreboard;
        int unsigned  code_first [0:31];
        int unsigned  code_num   [0:31];
        int unsigned  code_base  [0:31];
        int unsigned  sorted_sym [0:SymCount-1];
        int unsigned  sym_code   [0:SymCount-1];
        longint unsigned acc_bits;
        int unsigned  acc_cnt;
        bit           eos_seen;
        t_dec_res     pending_q[$];
        int           n_mismatch;

        function void build();
            int unsigned code;
            int unsigned pos;
            code = 0;
            pos  = 0;
            for (int l = 1; l <= MaxLen; l++) begin
                code_num[l]   = 0;
                code_first[l] = code;
                code_base[l]  = pos;
                for (int s = 0; s < SymCount; s++) begin
                    if (int'(CODE_LEN[s]) == l) begin
                        sorted_sym[pos] = s;
                        sym_code[s]     = code + code_num[l];
                        pos++;
                        code_num[l]++;
                    end
                end
                code = (code + code_num[l]) << 1;
            end
            acc_bits   = 0;
            acc_cnt    = 0;
            eos_seen   = 0;
            n_mismatch = 0;
        endfunction

        // returns symbol or -1, length in len
        function int match(output int unsigned len);
            int unsigned top;
            len = 0;
            for (int l = MinLen; l <= MaxLen && l <= acc_cnt; l++) begin
                top = int'((acc_bits >> (acc_cnt - l)) & ((64'd1 << l) - 1));
                if (top >= code_first[l] && top - code_first[l] < code_num[l]) begin
                    len = l;
                    return int'(sorted_sym[code_base[l] + top - code_first[l]]);
                end
            end
            return -1;
        endfunction

        // predict the results of one accepted byte
        function void note_byte(logic [7:0] cb, logic eos);
            int          n;
            int          sym;
            int unsigned len;
            longint unsigned pad;
            t_dec_res    r;
            n = 0;
            if (!eos_seen) begin
                if (acc_cnt > 29) acc_cnt = 29;
                acc_bits = ((acc_bits << 8) | cb) & ((64'd1 << BufW) - 1);
                acc_cnt += 8;
                while (n < 7) begin
                    sym = match(len);
                    if (sym < 0) break;
                    if (sym == int'(EOS_SYM)) begin
                        eos_seen = 1;
                        acc_bits = 0;
                        acc_cnt  = 0;
                        break;
                    end
                    r = '{symbol: 8'(sym), kind: KIND_SYM, run_last: 1'b0};
                    pending_q = {pending_q, r};
                    n++;
                    acc_cnt -= len;
                    acc_bits &= (64'd1 << acc_cnt) - 1;
                end
            end
            if (eos) begin
                pad = (64'd1 << acc_cnt) - 1;
                r.symbol   = '0;
                r.kind     = (!eos_seen && acc_cnt <= 7 && (acc_bits & pad) == pad)
                             ? KIND_OK : KIND_BADPAD;
                r.run_last = 1'b0;
                pending_q = {pending_q, r};
                n++;
                acc_bits = 0;
                acc_cnt  = 0;
                eos_seen = 0;
            end
            if (n > 0) pending_q[pending_q.size()-1].run_last = 1'b1;
        endfunction

        function void check(t_dec_res got);
            t_dec_res exp_r;
            if (pending_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result sym=%0h kind=%0d last=%0b",
                             got.symbol, got.kind, got.run_last);
                return;
            end
            exp_r = pending_q.pop_front();
            if (got !== exp_r) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: exp sym=%0h kind=%0d last=%0b, got sym=%0h kind=%0d last=%0b",
                             exp_r.symbol, exp_r.kind, exp_r.run_last,
                             got.symbol, got.kind, got.run_last);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_eos;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_symbol;
    logic [1:0] out_kind;
    logic       out_last;

    huff_scoreboard sb;
    int unsigned    cycle_cnt;
    byte unsigned   str_q[$];
    bit             hold_rx;

    hpack_huffman_decoder_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_code_byte     (in_byte),
        .i_end_of_string (in_eos),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_symbol        (out_symbol),
        .o_kind          (out_kind),
        .o_run_last      (out_last)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // check results and timeout
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && out_valid && out_ready)
            sb.check('{symbol: out_symbol, kind: out_kind, run_last: out_last});
        if (cycle_cnt > 600000) begin
            $display("hpack_huffman_decoder_core regression: fail");
            $finish;
        end
    end

    // receiver stall pattern: long free runs, then bursts of random stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_rx) begin
            out_ready <= 1'b1;
        end else if (cycle_cnt[9:8] == 2'd0) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // one transaction on the input side
    task automatic send_byte(input logic [7:0] b, input logic eos);
        in_valid <= 1'b1;
        in_byte  <= b;
        in_eos   <= eos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(b, eos);
    endtask

    task automatic idle_gap(input int unsigned n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // send a packed byte string, the last byte marked end of string
    task automatic send_bits(input logic [7:0] bits_q[$], input bit gaps);
        for (int i = 0; i < bits_q.size(); i++) begin
            send_byte(bits_q[i], i == bits_q.size() - 1);
            if (gaps && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
        end
    endtask

    // encode symbols into bytes; pad_mode 0 ones, 1 random, 2 extra byte of ones
    task automatic send_string(input int syms[$], input int pad_mode, input bit gaps);
        logic [7:0]      out_q[$];
        longint unsigned acc;
        int unsigned     cnt;
        int unsigned     len;
        acc = 0;
        cnt = 0;
        foreach (syms[i]) begin
            len = int'(CODE_LEN[syms[i]]);
            acc = (acc << len) | sb.sym_code[syms[i]];
            cnt += len;
            while (cnt >= 8) begin
                out_q = {out_q, 8'(acc >> (cnt - 8))};
                cnt -= 8;
                acc &= (64'd1 << cnt) - 1;
            end
        end
        if (cnt > 0) begin
            acc = (acc << (8 - cnt)) |
                  ((pad_mode == 1) ? $urandom_range(0, (1 << (8 - cnt)) - 1)
                                   : ((1 << (8 - cnt)) - 1));
            out_q = {out_q, 8'(acc)};
        end
        if (pad_mode == 2 || out_q.size() == 0) out_q = {out_q, 8'hff};
        send_bits(out_q, gaps);
    endtask

    int syms[$];
    int r;

    initial begin
        sb = new();
        sb.build();
        cycle_cnt = 0;
        hold_rx   = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = '0;
        in_eos    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-remainder and extremes of the byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h08, 1'b1);
        // shortest codes in a run, then longest symbols
        syms = '{48, 48, 48, 48, 48, 48, 48, 48, 49, 97};
        send_string(syms, 0, 0);
        syms = '{10, 13, 22, 0, 255};
        send_string(syms, 0, 0);
        // bad padding: random bits, and too many ones
        syms = '{97};
        send_string(syms, 1, 0);
        send_string(syms, 2, 0);
        // EOS inside data: four 0xff bytes, then more data
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h12, 1'b1);

        // drain with the sender paused
        idle_gap(1);
        hold_rx = 1;
        while (sb.pending_q.size() != 0) @(posedge clk);
        hold_rx = 0;

        // random strings, about 330 bytes total
        for (int n = 0; n < 100; n++) begin
            syms.delete();
            r = $urandom_range(0, 9);
            if (r < 7) begin
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 4) == 0) syms = {syms, int'($urandom_range(0, 255))};
                    else syms = {syms, int'($urandom_range(32, 126))};
                end
                send_string(syms, (r == 6) ? $urandom_range(1, 2) : 0, 1);
            end else if (r < 9) begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom), 1'b0);
                end
                send_byte(8'($urandom), 1'b1);
            end else begin
                syms = {syms, int'($urandom_range(32, 126))};
                syms = {syms, 256};
                syms = {syms, int'($urandom_range(32, 126))};
                send_string(syms, 0, 1);
            end
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 12));
        end
        in_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.n_mismatch == 0 && sb.pending_q.size() == 0) begin
            $display("hpack_huffman_decoder_core regression: pass");
        end else begin
            $display("hpack_huffman_decoder_core regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/hpk_pkg.sv
hw/rtl/hpk_code_match.sv
hw/rtl/hpack_huffman_decoder_core.sv
tb/hpack_huffman_decoder_core_tb.sv
